/* src/bmprle_pkg.sv */
package bmprle_pkg;

   localparam int CFG_W           = 13;
   localparam int DEFAULT_MAX_DIM = 4096;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CSR_IDX_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_image;
   } req_type;

   typedef struct packed {
      logic [11:0] row;
      logic [11:0] column;
      logic [7:0]  run_length;
      logic [7:0]  pixel_first;
      logic [7:0]  pixel_second;
      logic        out_of_range;
      logic        image_done;
   } rsp_type;

   // Zero acts as one, anything above the limit acts as the limit.
   function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] v,
                                             input logic [31:0] lim);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0) begin
         return 32'd1;
      end else if (v32 > lim) begin
         return lim;
      end else begin
         return v32;
      end
   endfunction

endpackage

/* src/bmprle_front.sv */
module bmprle_front #(
   parameter int MAX_DIM = bmprle_pkg::DEFAULT_MAX_DIM,
   localparam int ROW_W = $clog2(MAX_DIM),
   localparam int COL_W = $clog2(2 * MAX_DIM),
   localparam int CMD_W = ROW_W + COL_W + 3 * 8 + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bmprle_pkg::req_type                  req_payload,
   input  logic                                 mode_rle4,
   input  logic [bmprle_pkg::CFG_W-1:0]         image_height,
   input  logic                                 q_full,
   output logic                                 q_push,
   output logic [CMD_W-1:0]                     q_data
);
   import bmprle_pkg::*;

   localparam logic [2:0] PH_CODE0 = 3'd0;
   localparam logic [2:0] PH_CODE1 = 3'd1;
   localparam logic [2:0] PH_ABS   = 3'd2;
   localparam logic [2:0] PH_PAD   = 3'd3;
   localparam logic [2:0] PH_DX    = 3'd4;
   localparam logic [2:0] PH_DY    = 3'd5;

   localparam logic [COL_W:0] COL_MAX = (COL_W + 1)'(2 * MAX_DIM - 1);

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [7:0]       len;
      logic [7:0]       p0;
      logic [7:0]       p1;
      logic             done;
   } cmd_type;

   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       count_ff, count_in;
   logic [7:0]       remain_ff, remain_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             finished_ff, finished_in;
   logic             pad_ff, pad_in;
   logic             accept;
   logic             emit;
   cmd_type          cmd;

   function automatic logic [COL_W-1:0] col_add(input logic [COL_W-1:0] c,
                                                input logic [7:0] n);
      logic [COL_W:0] sum;
      sum = {1'b0, c} + (COL_W + 1)'(n);
      if (sum > COL_MAX) begin
         return COL_MAX[COL_W-1:0];
      end else begin
         return sum[COL_W-1:0];
      end
   endfunction

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && emit;
   assign q_data    = CMD_W'(cmd);

   always_comb begin
      logic [7:0] b;
      logic [8:0] b_inc;
      logic [7:0] k;
      b           = req_payload.data_byte;
      b_inc       = {1'b0, b} + 9'd1;
      k           = 8'd1;
      phase_in    = phase_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      finished_in = finished_ff;
      pad_in      = pad_ff;
      emit        = 1'b0;
      cmd         = '0;

      if (req_payload.new_image) begin
         row_in      = ROW_W'(clamp_dim(image_height, 32'(MAX_DIM)) - 32'd1);
         col_in      = '0;
         phase_in    = PH_CODE0;
         count_in    = '0;
         remain_in   = '0;
         pad_in      = 1'b0;
         finished_in = 1'b0;
      end

      if (!finished_in) begin
         case (phase_in)
            PH_CODE0: begin
               count_in = b;
               phase_in = PH_CODE1;
            end
            PH_CODE1: begin
               phase_in = PH_CODE0;
               if (count_in != 8'd0) begin
                  emit     = 1'b1;
                  cmd.row  = row_in;
                  cmd.col  = col_in;
                  cmd.len  = count_in;
                  cmd.p0   = mode_rle4 ? {4'd0, b[7:4]} : b;
                  cmd.p1   = mode_rle4 ? {4'd0, b[3:0]} : b;
                  col_in   = col_add(col_in, count_in);
               end else if (b == 8'd0) begin
                  // end of line: step one row up, or finish on the last row
                  if (row_in == '0) begin
                     emit        = 1'b1;
                     cmd.done    = 1'b1;
                     finished_in = 1'b1;
                  end else begin
                     row_in = row_in - ROW_W'(1);
                     col_in = '0;
                  end
               end else if (b == 8'd1) begin
                  emit        = 1'b1;
                  cmd.done    = 1'b1;
                  finished_in = 1'b1;
               end else if (b == 8'd2) begin
                  phase_in = PH_DX;
               end else begin
                  remain_in = b;
                  pad_in    = mode_rle4 ? b_inc[1] : b[0];
                  phase_in  = PH_ABS;
               end
            end
            PH_ABS: begin
               if (mode_rle4 && remain_in >= 8'd2) begin
                  k = 8'd2;
               end
               emit    = 1'b1;
               cmd.row = row_in;
               cmd.col = col_in;
               cmd.len = k;
               cmd.p0  = mode_rle4 ? {4'd0, b[7:4]} : b;
               cmd.p1  = mode_rle4 ? {4'd0, b[3:0]} : b;
               col_in  = col_add(col_in, k);
               remain_in = (remain_in > k) ? remain_in - k : 8'd0;
               if (remain_in == 8'd0) begin
                  phase_in = pad_in ? PH_PAD : PH_CODE0;
               end
            end
            PH_PAD: begin
               pad_in   = 1'b0;
               phase_in = PH_CODE0;
            end
            PH_DX: begin
               col_in   = col_add(col_in, b);
               phase_in = PH_DY;
            end
            PH_DY: begin
               phase_in = PH_CODE0;
               if (32'(b) > 32'(row_in)) begin
                  emit        = 1'b1;
                  cmd.done    = 1'b1;
                  finished_in = 1'b1;
               end else begin
                  row_in = row_in - ROW_W'(b);
               end
            end
            default: begin
               phase_in = PH_CODE0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CODE0;
         count_ff    <= '0;
         remain_ff   <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         finished_ff <= 1'b1;
         pad_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         remain_ff   <= remain_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         finished_ff <= finished_in;
         pad_ff      <= pad_in;
      end
   end

endmodule

/* src/bmprle_queue.sv */
module bmprle_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] head_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (32'(p) == DEPTH - 1) begin
         return '0;
      end else begin
         return p + PTR_W'(1);
      end
   endfunction

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

/* src/bmprle_back.sv */
module bmprle_back #(
   parameter int MAX_DIM = bmprle_pkg::DEFAULT_MAX_DIM,
   localparam int ROW_W = $clog2(MAX_DIM),
   localparam int COL_W = $clog2(2 * MAX_DIM),
   localparam int CMD_W = ROW_W + COL_W + 3 * 8 + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_not_empty,
   input  logic [CMD_W-1:0]             q_data,
   output logic                         q_pop,
   input  logic [bmprle_pkg::CFG_W-1:0] image_width,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bmprle_pkg::rsp_type          rsp_payload
);
   import bmprle_pkg::*;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [7:0]       len;
      logic [7:0]       p0;
      logic [7:0]       p1;
      logic             done;
   } cmd_type;

   cmd_type     cmd;
   logic        valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] w, c32, n32, avail, len, shown, row32;

   assign cmd       = cmd_type'(q_data);
   assign q_pop     = q_not_empty && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_payload = rsp_ff;

   // Clip the run against the image width.
   always_comb begin
      w      = clamp_dim(image_width, 32'(MAX_DIM));
      c32    = 32'(cmd.col);
      n32    = 32'(cmd.len);
      row32  = 32'(cmd.row);
      avail  = (c32 < w) ? w - c32 : 32'd0;
      len    = (n32 < avail) ? n32 : avail;
      shown  = (c32 < 32'(MAX_DIM)) ? c32 : 32'(MAX_DIM - 1);
      rsp_in = '0;
      if (cmd.done) begin
         rsp_in.image_done = 1'b1;
      end else begin
         rsp_in.row          = row32[11:0];
         rsp_in.column       = shown[11:0];
         rsp_in.run_length   = len[7:0];
         rsp_in.pixel_first  = cmd.p0;
         rsp_in.pixel_second = cmd.p1;
         rsp_in.out_of_range = (n32 > avail);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* src/bmp_rle8_rle4_decoder.sv */
// Run-length bitmap decoder, RLE8 or RLE4, one compressed byte per transaction.
// Request channel (req_valid/req_ready/req_payload) takes the data byte and a
// new_image flag that restarts decoding at the bottom row, column 0.
// Response channel (rsp_valid/rsp_ready/rsp_payload) gives one run descriptor
// per byte that completes a run, or a done-only descriptor at end of bitmap.
// CSR port: write csr_wdata to register csr_index when csr_we is high
// (0 decode mode, 1 width, 2 height); write only while the block is idle.
// Throughput: one byte per cycle while the queue is not full. The parser
// updates its phase, row and column for each byte and pushes finished runs
// into a 4-entry queue. A run enters the queue at the edge that accepts its
// byte; the back end then pops it into the output register behind rsp_valid,
// clipping it against the width while loading that register.
// When the receiver stalls, the output register holds and the queue fills;
// req_ready drops only when the queue is full.
// Reset empties the queue and the output register, loads mode RLE8, width 1,
// height 1, and leaves the parser finished: bytes are dropped until a
// transaction with new_image set.
module bmp_rle8_rle4_decoder #(
   parameter int MAX_DIM = bmprle_pkg::DEFAULT_MAX_DIM
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bmprle_pkg::req_type              req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bmprle_pkg::rsp_type              rsp_payload,
   input  logic                             csr_we,
   input  logic [bmprle_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bmprle_pkg::CFG_W-1:0]     csr_wdata
);
   import bmprle_pkg::*;

   localparam int ROW_W = $clog2(MAX_DIM);
   localparam int COL_W = $clog2(2 * MAX_DIM);
   localparam int CMD_W = ROW_W + COL_W + 3 * 8 + 1;

   logic             mode_ff;
   logic [CFG_W-1:0] width_ff, height_ff;
   logic             q_full, q_push, q_pop, q_not_empty;
   logic [CMD_W-1:0] push_data, head_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_DECODE_MODE:  mode_ff   <= csr_wdata[0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   bmprle_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .mode_rle4   (mode_ff),
      .image_height(height_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (push_data)
   );

   bmprle_queue #(.DATA_W(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (head_data)
   );

   bmprle_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (head_data),
      .q_pop       (q_pop),
      .image_width (width_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_done_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.image_done |->
         rsp_payload.run_length == 8'd0 && !rsp_payload.out_of_range)
      else $error("end-of-bitmap descriptor carries a run");

   a_run_within_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_payload.run_length) <= clamp_dim(width_ff, 32'(MAX_DIM)))
      else $error("clipped run longer than image width");

endmodule
